/* hw/rtl/sonar_reply_frame_parser_defines.svh */
// assertion macros for the sonar reply frame parser checker
// used by srfp_checker; expects clk and rst in scope
`ifndef SONAR_REPLY_FRAME_PARSER_DEFINES_SVH
`define SONAR_REPLY_FRAME_PARSER_DEFINES_SVH

// same-cycle implication, off during reset
`define SRFP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define SRFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/srfp_pkg.sv */
// shared types and constants for the sonar reply frame parser
// no dependencies
`default_nettype none

package srfp_pkg;

  // frame bytes and message ids
  localparam logic [7:0] START_BYTE = 8'h52;
  localparam logic [7:0] ID_OK      = 8'd79;
  localparam logic [7:0] ID_FIN     = 8'd70;
  localparam logic [7:0] ID_MEASURE = 8'd77;
  localparam logic [7:0] ID_POS     = 8'd80;
  localparam logic [7:0] ID_ERR_L   = 8'd76;
  localparam logic [7:0] ID_ERR_D   = 8'd78;

  // result status codes
  localparam logic [2:0] STATUS_NONE    = 3'd0;
  localparam logic [2:0] STATUS_CKSUM   = 3'd1;
  localparam logic [2:0] STATUS_BAD_ID  = 3'd2;
  localparam logic [2:0] STATUS_DEV_L   = 3'd3;
  localparam logic [2:0] STATUS_DEV_D   = 3'd4;

  // parser positions
  localparam logic [2:0] POS_HUNT    = 3'd0;
  localparam logic [2:0] POS_ID      = 3'd1;
  localparam logic [2:0] POS_PAY0    = 3'd2;
  localparam logic [2:0] POS_PAY1    = 3'd3;
  localparam logic [2:0] POS_PAY2    = 3'd4;
  localparam logic [2:0] POS_PAY3    = 3'd5;
  localparam logic [2:0] POS_CK_HIGH = 3'd6;
  localparam logic [2:0] POS_CK_LOW  = 3'd7;

  // output word layout
  localparam int OUT_W = 64;

  // one completed frame, handed from the parser to the result stage
  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] time_word;
    logic [15:0] depth_word;
    logic        ck_bad;
  } frame_rec_t;

  // queue status seen by the two sides
  typedef struct packed {
    logic full;
    logic head_valid;
  } queue_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/sonar_reply_frame_parser.sv */
// top level of the sonar reply frame parser
// depends on srfp_pkg, srfp_front, srfp_queue, srfp_back
`default_nettype none

// Takes one received byte per cycle on the s_ side, hunts for the 0x52
// start byte, then reads the id, two payload bytes for OK (79) or four for
// any other id, and a big-endian 16-bit sum checksum. Each completed frame
// gives one word on the m_ side, carried first through the record queue
// and then through the output register. A byte
// can enter every cycle; s_tready drops only when the two-entry record
// queue is full, which happens only while the m_ side stalls. Status codes:
// 0 none, 1 checksum error (overrides all others), 2 unexpected id,
// 3 device error L, 4 device error D. Time and depth are the last decoded
// values; the checksum error count saturates at 65535.

module sonar_reply_frame_parser
  import srfp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [7:0]       s_tdata,   // rx_byte
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  // msg_id[7:0], time_value[23:8], depth_value[39:24], status[42:40],
  // checksum_errors[58:43], sweep_finished[59], zero[63:60]
  output logic [OUT_W-1:0]      m_tdata
);

  logic        byte_take;
  logic        rec_push;
  logic        pop;
  frame_rec_t  rec;
  frame_rec_t  head;
  queue_stat_t stat;

  assign s_tready  = !stat.full;
  assign byte_take = s_tvalid && s_tready;

  // parser front
  srfp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .byte_take (byte_take),
    .rx_byte   (s_tdata),
    .rec_push  (rec_push),
    .rec       (rec)
  );

  // record queue
  srfp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (rec_push),
    .push_rec (rec),
    .pop      (pop),
    .head     (head),
    .stat     (stat)
  );

  // result stage
  srfp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .stat     (stat),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire

/* hw/rtl/srfp_front.sv */
// byte parser: hunts the start byte, collects id, payload and checksum
// depends on srfp_pkg
`default_nettype none

module srfp_front
  import srfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       byte_take,
  input  wire logic [7:0] rx_byte,
  output logic            rec_push,
  output frame_rec_t      rec
);

  logic [2:0]  pos;
  logic [7:0]  frame_id;
  logic [7:0]  pay [4];
  logic [15:0] running_sum;
  logic [7:0]  ck_high;
  logic [15:0] sum_next;

  assign sum_next = running_sum + {8'd0, rx_byte};

  // frame record leaves on the closing checksum byte
  assign rec_push       = byte_take && (pos == POS_CK_LOW);
  assign rec.id         = frame_id;
  assign rec.time_word  = {pay[0], pay[1]};
  assign rec.depth_word = {pay[2], pay[3]};
  assign rec.ck_bad     = ({ck_high, rx_byte} != running_sum);

  // position sequencer and byte capture
  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= POS_HUNT;
      frame_id    <= 8'd0;
      pay[0]      <= 8'd0;
      pay[1]      <= 8'd0;
      pay[2]      <= 8'd0;
      pay[3]      <= 8'd0;
      running_sum <= 16'd0;
      ck_high     <= 8'd0;
    end else if (byte_take) begin
      case (pos)
        POS_HUNT: begin
          if (rx_byte == START_BYTE) begin
            pay[0]      <= 8'd0;
            pay[1]      <= 8'd0;
            pay[2]      <= 8'd0;
            pay[3]      <= 8'd0;
            running_sum <= {8'd0, rx_byte};
            pos         <= POS_ID;
          end
        end
        POS_ID: begin
          frame_id    <= rx_byte;
          running_sum <= sum_next;
          pos         <= POS_PAY0;
        end
        POS_PAY0, POS_PAY1, POS_PAY2, POS_PAY3: begin
          pay[pos[1:0] - 2'd2] <= rx_byte;
          running_sum          <= sum_next;
          // ok frames carry only the time field
          if (pos == POS_PAY1 && frame_id == ID_OK) begin
            pos <= POS_CK_HIGH;
          end else begin
            pos <= pos + 3'd1;
          end
        end
        POS_CK_HIGH: begin
          ck_high <= rx_byte;
          pos     <= POS_CK_LOW;
        end
        default: begin
          pos <= POS_HUNT;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/srfp_queue.sv */
// two-entry frame record queue between parser and result stage
// depends on srfp_pkg
`default_nettype none

module srfp_queue
  import srfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire frame_rec_t push_rec,
  input  wire logic       pop,
  output frame_rec_t      head,
  output queue_stat_t     stat
);

  frame_rec_t  mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign stat.full       = (count == 2'd2);
  assign stat.head_valid = (count != 2'd0);
  assign head            = mem[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/srfp_back.sv */
// result stage: decodes the id, updates held values and error count,
// drives the output register; depends on srfp_pkg
`default_nettype none

module srfp_back
  import srfp_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire frame_rec_t      head,
  input  wire queue_stat_t     stat,
  output logic                 pop,
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  output logic [OUT_W-1:0]     m_tdata
);

  logic [15:0] held_time;
  logic [15:0] held_depth;
  logic [15:0] error_counter;
  logic [15:0] time_next;
  logic [15:0] depth_next;
  logic [15:0] errors_next;
  logic [2:0]  status;
  logic        is_fin;

  assign pop    = stat.head_valid && (!m_tvalid || m_tready);
  assign is_fin = (head.id == ID_FIN);

  // id decode and checksum override
  always_comb begin
    time_next   = held_time;
    depth_next  = held_depth;
    errors_next = error_counter;
    status      = STATUS_NONE;
    if (head.id == ID_OK) begin
      time_next = head.time_word;
    end else if (is_fin || head.id == ID_MEASURE || head.id == ID_POS) begin
      time_next  = head.time_word;
      depth_next = head.depth_word;
    end else if (head.id == ID_ERR_L) begin
      status = STATUS_DEV_L;
    end else if (head.id == ID_ERR_D) begin
      status = STATUS_DEV_D;
    end else begin
      status = STATUS_BAD_ID;
    end
    if (head.ck_bad) begin
      status = STATUS_CKSUM;
      if (error_counter != 16'hFFFF) begin
        errors_next = error_counter + 16'd1;
      end
    end
  end

  // held state
  always_ff @(posedge clk) begin
    if (rst) begin
      held_time     <= 16'd0;
      held_depth    <= 16'd0;
      error_counter <= 16'd0;
    end else if (pop) begin
      held_time     <= time_next;
      held_depth    <= depth_next;
      error_counter <= errors_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_tdata <= {4'd0, is_fin, errors_next, status, depth_next, time_next, head.id};
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/srfp_checker.sv */
// port-level checks for the sonar reply frame parser, bound to the top
// depends on srfp_pkg and sonar_reply_frame_parser_defines.svh
`default_nettype none

`include "sonar_reply_frame_parser_defines.svh"

module srfp_checker
  import srfp_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             m_tvalid,
  input wire logic             m_tready,
  input wire logic [OUT_W-1:0] m_tdata
);

  logic [7:0]  id_f;
  logic [2:0]  status_f;
  logic [15:0] count_f;
  logic        fin_f;
  logic [3:0]  pad_f;

  // result word fields
  assign id_f     = m_tdata[7:0];
  assign status_f = m_tdata[42:40];
  assign count_f  = m_tdata[58:43];
  assign fin_f    = m_tdata[59];
  assign pad_f    = m_tdata[63:60];

  // stalled result word holds
  `SRFP_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stall lost")

  // no result right after reset
  `SRFP_ASSERT_NOW(a_reset, $past(rst), !m_tvalid, "result valid right after reset")

  // status is a known code and padding is zero
  `SRFP_ASSERT_NOW(a_status, m_tvalid, status_f <= STATUS_DEV_D && pad_f == 4'd0, "bad status")

  // a checksum error always has a nonzero count
  `SRFP_ASSERT_NOW(a_count, m_tvalid && status_f == STATUS_CKSUM, count_f != 16'd0, "zero count")

  // sweep flag matches the fin id
  `SRFP_ASSERT_NOW(a_fin, m_tvalid, fin_f == (id_f == ID_FIN), "sweep flag disagrees with id")

endmodule

bind sonar_reply_frame_parser srfp_checker u_srfp_checker (.*);

`default_nettype wire
